@@ rtl/core/sdet_pkg.sv @@
// Shared widths, opcodes, status codes and defaults of the strength decay entry table.
// No dependencies.
`default_nettype none
package sdet_pkg;
    localparam int CAPACITY_DEF     = 512;
    localparam int MAX_HALVINGS_DEF = 30;
    localparam int KEY_BITS_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int OP_W   = 3;
    localparam int KEY_W  = 64;
    localparam int PAY_W  = 32;
    localparam int TIME_W = 48;
    localparam int STR_W  = 32;
    localparam int IDX_W  = 9;
    localparam int ST_W   = 3;
    localparam int CNT_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_ADD       = 3'd0,
        OP_REINFORCE = 3'd1,
        OP_DECAY     = 3'd2,
        OP_DROP      = 3'd3,
        OP_READ      = 3'd4,
        OP_COUNT     = 3'd5
    } sdet_op_t;

    localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
    localparam logic [ST_W-1:0] ST_FOUND   = 3'd1;
    localparam logic [ST_W-1:0] ST_EVICTED = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [ST_W-1:0] ST_MISSING = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LIFE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_THR  = 2'd2;

    localparam logic [STR_W-1:0] ONE_Q16       = 32'h0001_0000;
    localparam logic [STR_W-1:0] FLOOR_DEFAULT = 32'd66;
    localparam logic [STR_W-1:0] STR_MAX       = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

@@ rtl/core/sdet_req_if.sv @@
// Request channel of the strength decay entry table: valid, ready and the request fields.
// Depends on sdet_pkg.
`default_nettype none
interface sdet_req_if;
    import sdet_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [KEY_W-1:0]     key;
    logic [PAY_W-1:0]     payload;
    logic [TIME_W-1:0]    timestamp;
    logic [STR_W-1:0]     initial_strength;
    logic [IDX_W-1:0]     index;

    modport source (output valid, opcode, key, payload, timestamp, initial_strength, index,
                    input ready);
    modport sink   (input valid, opcode, key, payload, timestamp, initial_strength, index,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/core/sdet_rsp_if.sv @@
// Result channel of the strength decay entry table: valid, ready and the result fields.
// Depends on sdet_pkg.
`default_nettype none
interface sdet_rsp_if;
    import sdet_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ST_W-1:0]      status;
    logic [CNT_W-1:0]     affected;
    logic [CNT_W-1:0]     entry_count;
    logic [KEY_W-1:0]     entry_key;
    logic [PAY_W-1:0]     entry_payload;
    logic [TIME_W-1:0]    entry_time;
    logic [STR_W-1:0]     entry_strength;

    modport source (output valid, status, affected, entry_count, entry_key, entry_payload,
                    entry_time, entry_strength, input ready);
    modport sink   (input valid, status, affected, entry_count, entry_key, entry_payload,
                    entry_time, entry_strength, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sdet_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module sdet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/strength_decay_entry_table.sv @@
// Strength decay entry table, top level. Depends on sdet_pkg, sdet_req_if, sdet_rsp_if, sdet_ram.
// Flow, accept to result valid: add/reinforce search the entries newest first and end on a hit
//   or in the miss step; decay reads every entry and runs the halving loop on each one old
//   enough; drop reads every entry; read waits on one RAM read; count, and decay/drop when
//   disabled, go to the result, held until the result register is free. One request at a time.
// Reset: control state, count and oldest pointer cleared; no clearing pass, entry RAM unset.
`default_nettype none
module strength_decay_entry_table
    import sdet_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int MAX_HALVINGS = MAX_HALVINGS_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [sdet_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [sdet_pkg::CFG_DATA_W-1:0]   cfg_data,
    sdet_req_if.sink                         req,
    sdet_rsp_if.source                       rsp
);
    import sdet_pkg::*;

    localparam int AW  = $clog2(CAPACITY);       // RAM address
    localparam int CW  = $clog2(CAPACITY + 1);   // count, can hold CAPACITY
    localparam int PW  = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam int KW  = KEY_BITS;
    localparam int HW  = $clog2(MAX_HALVINGS + 1);
    localparam int ACW = TIME_W + HW + 1;        // half_life * (halvings + 1)
    localparam int IXW = (IDX_W > CW) ? IDX_W : CW;
    localparam int DW  = KW + PW + TIME_W + STR_W;
    // word layout: {key, payload, time, strength}
    localparam int S_LO = 0;
    localparam int T_LO = STR_W;
    localparam int P_LO = STR_W + TIME_W;
    localparam int K_LO = STR_W + TIME_W + PW;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_MISS, S_DEC_RD, S_DEC_CHK, S_DEC_STEP,
        S_DROP_RD, S_DROP_CHK, S_RD_WAIT, S_FINISH
    } state_t;

    state_t             state_reg;
    logic [OP_W-1:0]    op_reg;
    logic [KW-1:0]      key_reg;
    logic [PW-1:0]      pay_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [STR_W-1:0]   init_reg;
    logic [CW-1:0]      held_reg;
    logic [AW-1:0]      oldest_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      w_reg;
    logic [CW-1:0]      aff_reg;
    logic [ST_W-1:0]    status_reg;
    logic [DW-1:0]      ent_reg;
    logic               rd_hit_reg;
    logic [STR_W-1:0]   ns_reg;
    logic [HW-1:0]      h_reg;
    logic [ACW-1:0]     acc_reg;
    logic [TIME_W-1:0]  age_reg;

    // configuration
    logic [TIME_W-1:0]  half_life_reg;
    logic [STR_W-1:0]   floor_reg;
    logic [STR_W-1:0]   thr_reg;

    // result register
    logic               out_valid_reg;
    logic [ST_W-1:0]    out_status_reg;
    logic [CNT_W-1:0]   out_aff_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic [KEY_W-1:0]   out_key_reg;
    logic [PAY_W-1:0]   out_pay_reg;
    logic [TIME_W-1:0]  out_time_reg;
    logic [STR_W-1:0]   out_str_reg;

    // entry RAM
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [DW-1:0]      ram_rdata;

    sdet_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // logical position to ring slot; one subtraction wraps any position up to CAPACITY
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] oldest,
                                              input logic [CW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, oldest} + (AW+1)'(pos);
        if (sum >= (AW+1)'(CAPACITY))
        begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [STR_W-1:0] sat_add_one(input logic [STR_W-1:0] s);
        return (s > STR_MAX - ONE_Q16) ? STR_MAX : s + ONE_Q16;
    endfunction

    logic [KW-1:0]      rd_key;
    logic [TIME_W-1:0]  rd_time;
    logic [STR_W-1:0]   rd_str;
    logic [STR_W-1:0]   floor_eff;
    logic [STR_W-1:0]   dec_final;
    logic               dec_more;
    logic [CW-1:0]      i_dec;
    logic [AW-1:0]      oldest_plus1;

    assign rd_key       = ram_rdata[K_LO +: KW];
    assign rd_time      = ram_rdata[T_LO +: TIME_W];
    assign rd_str       = ram_rdata[S_LO +: STR_W];
    assign floor_eff    = (floor_reg != '0) ? floor_reg : FLOOR_DEFAULT;
    assign dec_more     = (h_reg < HW'(MAX_HALVINGS)) && (acc_reg <= ACW'(age_reg))
                          && (ns_reg > floor_eff);
    assign dec_final    = (ns_reg < floor_eff) ? floor_eff : ns_reg;
    assign i_dec        = i_reg - CW'(1);
    assign oldest_plus1 = slot_of(oldest_reg, CW'(1));

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.affected       = out_aff_reg;
    assign rsp.entry_count    = out_cnt_reg;
    assign rsp.entry_key      = out_key_reg;
    assign rsp.entry_payload  = out_pay_reg;
    assign rsp.entry_time     = out_time_reg;
    assign rsp.entry_strength = out_str_reg;

    // RAM port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_of(oldest_reg, i_reg);
        ram_wdata = ram_rdata;
        ram_raddr = slot_of(oldest_reg, i_reg);
        unique case (state_reg)
            S_SRCH_RD:
            begin
                ram_raddr = slot_of(oldest_reg, i_dec);
            end
            S_SRCH_CMP:
            begin
                // hit: new time and reinforced strength, add also replaces the payload
                ram_we    = (rd_key == key_reg);
                ram_wdata[T_LO +: TIME_W] = now_reg;
                ram_wdata[S_LO +: STR_W]  = sat_add_one(rd_str);
                if (op_reg == OP_ADD)
                begin
                    ram_wdata[P_LO +: PW] = pay_reg;
                end
            end
            S_MISS:
            begin
                ram_we    = (op_reg == OP_ADD);
                // when full the new entry lands on the evicted oldest slot
                ram_waddr = (held_reg == CW'(CAPACITY)) ? oldest_reg
                                                        : slot_of(oldest_reg, held_reg);
                ram_wdata = {key_reg, pay_reg, now_reg,
                             (init_reg != '0) ? init_reg : ONE_Q16};
            end
            S_DEC_STEP:
            begin
                ram_we    = !dec_more && (dec_final != ent_reg[S_LO +: STR_W]);
                ram_wdata = {ent_reg[DW-1:STR_W], dec_final};
            end
            S_DROP_CHK:
            begin
                ram_we    = (rd_str >= thr_reg);
                ram_waddr = slot_of(oldest_reg, w_reg);
            end
            S_IDLE:
            begin
                ram_raddr = slot_of(oldest_reg, CW'(req.index));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
            half_life_reg <= '0;
            floor_reg     <= FLOOR_DEFAULT;
            thr_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HALF_LIFE: half_life_reg <= cfg_data;
                    CFG_FLOOR:     floor_reg     <= cfg_data[STR_W-1:0];
                    CFG_DROP_THR:  thr_reg       <= cfg_data[STR_W-1:0];
                    default:       ;
                endcase
            end

            // in S_FINISH the result register is reloaded instead
            if (out_valid_reg && rsp.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg     <= req.opcode;
                        key_reg    <= req.key[KW-1:0];
                        pay_reg    <= req.payload[PW-1:0];
                        now_reg    <= req.timestamp;
                        init_reg   <= req.initial_strength;
                        aff_reg    <= '0;
                        status_reg <= ST_DONE;
                        rd_hit_reg <= 1'b0;
                        i_reg      <= '0;
                        w_reg      <= '0;
                        unique case (req.opcode)
                            OP_ADD, OP_REINFORCE:
                            begin
                                i_reg     <= held_reg;
                                state_reg <= S_SRCH_RD;
                            end
                            OP_DECAY:
                            begin
                                state_reg <= (half_life_reg != '0) ? S_DEC_RD : S_FINISH;
                            end
                            OP_DROP:
                            begin
                                state_reg <= (thr_reg != '0) ? S_DROP_RD : S_FINISH;
                            end
                            OP_READ:
                            begin
                                // read address already issued from the index this cycle
                                if (IXW'(req.index) < IXW'(held_reg))
                                begin
                                    state_reg <= S_RD_WAIT;
                                end
                                else
                                begin
                                    status_reg <= ST_RANGE;
                                    state_reg  <= S_FINISH;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_SRCH_RD:
                begin
                    if (i_reg == '0)
                    begin
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        i_reg     <= i_dec;
                        state_reg <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP:
                begin
                    if (rd_key == key_reg)
                    begin
                        status_reg <= ST_FOUND;
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_MISS:
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (held_reg == CW'(CAPACITY))
                        begin
                            oldest_reg <= oldest_plus1;
                            status_reg <= ST_EVICTED;
                        end
                        else
                        begin
                            held_reg <= held_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        status_reg <= ST_MISSING;
                    end
                    state_reg <= S_FINISH;
                end
                S_DEC_RD:
                begin
                    state_reg <= (i_reg == held_reg) ? S_FINISH : S_DEC_CHK;
                end
                S_DEC_CHK:
                begin
                    // entries from the future or younger than one half-life are skipped
                    if ((now_reg < rd_time) || ((now_reg - rd_time) < half_life_reg))
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_DEC_RD;
                    end
                    else
                    begin
                        age_reg   <= now_reg - rd_time;
                        ent_reg   <= ram_rdata;
                        ns_reg    <= rd_str;
                        h_reg     <= '0;
                        acc_reg   <= ACW'(half_life_reg);
                        state_reg <= S_DEC_STEP;
                    end
                end
                S_DEC_STEP:
                begin
                    // one halving per cycle while (h+1)*half_life <= age, h < MAX_HALVINGS and strength > floor
                    if (dec_more)
                    begin
                        ns_reg  <= ns_reg >> 1;
                        h_reg   <= h_reg + HW'(1);
                        acc_reg <= acc_reg + ACW'(half_life_reg);
                    end
                    else
                    begin
                        if (dec_final != ent_reg[S_LO +: STR_W])
                        begin
                            aff_reg <= aff_reg + CW'(1);
                        end
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_DEC_RD;
                    end
                end
                S_DROP_RD:
                begin
                    if (i_reg == held_reg)
                    begin
                        held_reg  <= w_reg;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_DROP_CHK;
                    end
                end
                S_DROP_CHK:
                begin
                    // survivors are packed down in order
                    if (rd_str < thr_reg)
                    begin
                        aff_reg <= aff_reg + CW'(1);
                    end
                    else
                    begin
                        w_reg <= w_reg + CW'(1);
                    end
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= S_DROP_RD;
                end
                S_RD_WAIT:
                begin
                    ent_reg    <= ram_rdata;
                    rd_hit_reg <= 1'b1;
                    state_reg  <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_aff_reg    <= CNT_W'(aff_reg);
                        out_cnt_reg    <= CNT_W'(held_reg);
                        out_key_reg    <= rd_hit_reg ? KEY_W'(ent_reg[K_LO +: KW]) : '0;
                        out_pay_reg    <= rd_hit_reg ? PAY_W'(ent_reg[P_LO +: PW]) : '0;
                        out_time_reg   <= rd_hit_reg ? ent_reg[T_LO +: TIME_W] : '0;
                        out_str_reg    <= rd_hit_reg ? ent_reg[S_LO +: STR_W] : '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
